// ===== design/pooled_binary_search_tree_macros.svh =====
// Assertion macros for the pooled binary search tree.
// No dependencies; included by the modules that carry assertions.
`ifndef POOLED_BINARY_SEARCH_TREE_MACROS_SVH
`define POOLED_BINARY_SEARCH_TREE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PBST_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled during reset.
`define PBST_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/pbst_pkg.sv =====
// Shared types and constants of the pooled binary search tree.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package pbst_pkg;
	localparam int KEY_W      = 288;
	localparam int WORD_W     = 64;
	localparam int TAIL_W     = 32;
	localparam int OP_W       = 2;
	localparam int STATUS_W   = 2;
	localparam int IDX_OUT_W  = 10;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [OP_W-1:0] {
		OP_SEARCH   = 2'd0,
		OP_INSERT   = 2'd1,
		OP_DELETE   = 2'd2,
		OP_SMALLEST = 2'd3
	} op_t;

	localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

	// Result of comparing a stored node key with the probe key.
	typedef struct packed {
		logic eq;
		logic node_lt;
	} cmp_res_t;

	// Requests to the free-index stack.
	typedef struct packed {
		logic pop;
		logic push;
	} fs_ctrl_t;
endpackage
`default_nettype wire

// ===== design/pbst_ram.sv =====
// Generic simple dual-port RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none
module pbst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule
`default_nettype wire

// ===== design/pbst_key_cmp.sv =====
// Lexicographic signed comparison of a node key against the probe key.
// Depends on pbst_pkg.
`timescale 1ns / 1ps
`default_nettype none
module pbst_key_cmp (
	input  wire logic [pbst_pkg::KEY_W-1:0] node_key,
	input  wire logic [pbst_pkg::KEY_W-1:0] probe_key,
	output pbst_pkg::cmp_res_t              res
);
	logic [4:0] w_lt;
	logic [4:0] w_eq;

	always_comb begin
		for (int w = 0; w < 4; w++) begin
			w_lt[w] = $signed(node_key[w*pbst_pkg::WORD_W +: pbst_pkg::WORD_W])
				< $signed(probe_key[w*pbst_pkg::WORD_W +: pbst_pkg::WORD_W]);
			w_eq[w] = node_key[w*pbst_pkg::WORD_W +: pbst_pkg::WORD_W]
				== probe_key[w*pbst_pkg::WORD_W +: pbst_pkg::WORD_W];
		end
		w_lt[4] = $signed(node_key[pbst_pkg::KEY_W-1 -: pbst_pkg::TAIL_W])
			< $signed(probe_key[pbst_pkg::KEY_W-1 -: pbst_pkg::TAIL_W]);
		w_eq[4] = node_key[pbst_pkg::KEY_W-1 -: pbst_pkg::TAIL_W]
			== probe_key[pbst_pkg::KEY_W-1 -: pbst_pkg::TAIL_W];
		// The first unequal word decides.
		res.eq      = &w_eq;
		res.node_lt = 1'b0;
		for (int w = 4; w >= 0; w--) begin
			if (!w_eq[w]) begin
				res.node_lt = w_lt[w];
			end
		end
	end
endmodule
`default_nettype wire

// ===== design/pbst_free_stack.sv =====
// Free-index stack: hands out node indices and takes freed ones back, LIFO.
// Depends on pbst_pkg and pbst_ram.
`timescale 1ns / 1ps
`default_nettype none
module pbst_free_stack #(
	parameter int NODES = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire pbst_pkg::fs_ctrl_t       ctrl,
	input  wire logic [$clog2(NODES)-1:0] push_idx,
	output logic      [$clog2(NODES)-1:0] pop_idx,
	output logic                          empty
);
	localparam int IW = $clog2(NODES);
	localparam int CW = IW + 1;
	localparam logic [CW-1:0] FULL_CNT = CW'(NODES);

	logic [CW-1:0] count_q;
	logic [CW-1:0] low_q;     // lowest count ever reached; entries below are unwritten
	logic [CW-1:0] top_m1;
	logic          from_mem_q;
	logic [IW-1:0] reset_val_q;
	logic [IW-1:0] rdata;

	assign top_m1 = count_q - CW'(1);
	assign empty  = count_q == '0;

	pbst_ram #(.WIDTH(IW), .DEPTH(NODES)) u_stack_ram (
		.clk   (clk),
		.we    (ctrl.push && count_q < FULL_CNT),
		.waddr (count_q[IW-1:0]),
		.wdata (push_idx),
		.re    (ctrl.pop),
		.raddr (top_m1[IW-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= FULL_CNT;
			low_q   <= FULL_CNT;
		end else if (ctrl.pop) begin
			count_q <= top_m1;
			if (top_m1 < low_q) begin
				low_q <= top_m1;
			end
		end else if (ctrl.push && count_q < FULL_CNT) begin
			count_q <= count_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.pop) begin
			from_mem_q  <= top_m1 >= low_q;
			reset_val_q <= IW'(NODES - 1) - top_m1[IW-1:0];
		end
	end

	assign pop_idx = from_mem_q ? rdata : reset_val_q;
endmodule
`default_nettype wire

// ===== design/pooled_binary_search_tree.sv =====
// Top level of the pooled binary search tree: sequencer, node memories, result register.
// Depends on pbst_pkg, pbst_ram, pbst_key_cmp, pbst_free_stack and the macros header.
//
// Channel   Dir  Signals                        Contents
// s_*       in   s_tvalid s_tready s_tdata/tuser  request: tdata key, tuser opcode
// m_*       out  m_tvalid m_tready m_tdata/tuser  result: tdata node_index, tuser status
//
// A request walks the tree one level at a time, since every level needs a registered
// read of the node memories followed by a key comparison; the result register is then
// loaded in S_DONE and the sequencer returns to idle. A delete with two children adds
// the successor walk and the write states S_DEL_W1, S_DEL_W2 and S_DEL_W3 (only
// S_DEL_W2 otherwise), and an insert that allocates adds S_POP, S_INS_W and S_INS_L.
// Reset is asynchronous and clears the root, the free-stack count and the sequencer;
// the node memories are never cleared. A finished result waits in the output register
// while the next request is taken; the sequencer only stalls if a second result is
// ready before the first has been taken.
`timescale 1ns / 1ps
`default_nettype none
`include "pooled_binary_search_tree_macros.svh"
module pooled_binary_search_tree #(
	parameter int NODES = 1024
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [287:0] s_tdata,  // key_word0, key_word1, key_word2, key_word3, key_tail
	input  wire logic [1:0]  s_tuser,   // opcode
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [15:0]      m_tdata,   // node_index, then zero padding
	output logic [1:0]       m_tuser    // status
);
	localparam int IW = $clog2(NODES);
	localparam int LW = IW + 1;
	localparam logic [LW-1:0] NULL_LINK = LW'(NODES);

	typedef enum logic [3:0] {
		S_IDLE, S_WALK, S_MIN, S_SUCC, S_DEL_W1, S_DEL_W2, S_DEL_W3,
		S_POP, S_INS_W, S_INS_L, S_DONE
	} state_t;

	state_t                       state_q;
	pbst_pkg::op_t                op_q;
	logic [pbst_pkg::KEY_W-1:0]   key_q;
	logic [LW-1:0]                root_q;
	logic [IW-1:0]                cur_q;
	logic [LW-1:0]                par_q;   // parent on a hit, attach point on a miss
	logic                         side_q;  // 1 means right
	logic [LW-1:0]                lc_q;
	logic [LW-1:0]                rc_q;
	logic [IW-1:0]                s_q;
	logic [LW-1:0]                sp_q;
	logic [LW-1:0]                rs_q;
	logic [LW-1:0]                relink_q;
	logic                         two_q;
	logic [IW-1:0]                n_q;
	logic [pbst_pkg::STATUS_W-1:0] res_status_q;
	logic [IW-1:0]                res_idx_q;
	logic                         out_valid_q;
	logic [pbst_pkg::STATUS_W-1:0] out_status_q;
	logic [pbst_pkg::IDX_OUT_W-1:0] out_idx_q;

	logic [pbst_pkg::KEY_W-1:0] key_rd;
	logic [LW-1:0]              left_rd;
	logic [LW-1:0]              right_rd;
	logic [IW-1:0]              raddr;
	pbst_pkg::cmp_res_t         cmp;
	logic [LW-1:0]              next_link;
	logic                       accept;

	logic          key_we;
	logic          left_we;
	logic [IW-1:0] left_waddr;
	logic [LW-1:0] left_wdata;
	logic          right_we;
	logic [IW-1:0] right_waddr;
	logic [LW-1:0] right_wdata;

	pbst_pkg::fs_ctrl_t fs_ctrl;
	logic [IW-1:0]      pop_idx;
	logic               fs_empty;

	function automatic logic valid_link(input logic [LW-1:0] v);
		return v < NULL_LINK;
	endfunction

	assign s_tready = state_q == S_IDLE;
	assign accept   = s_tvalid && s_tready;
	assign next_link = cmp.node_lt ? right_rd : left_rd;

	// One read address serves all three node memories. On a hit the right child is
	// fetched, as it starts the successor walk of a two-child delete.
	always_comb begin
		case (state_q)
			S_IDLE:         raddr = root_q[IW-1:0];
			S_WALK:         raddr = cmp.eq ? right_rd[IW-1:0] : next_link[IW-1:0];
			S_MIN, S_SUCC:  raddr = left_rd[IW-1:0];
			default:        raddr = cur_q;
		endcase
	end

	// Node memory writes, one per memory per cycle.
	always_comb begin
		key_we      = state_q == S_INS_W;
		left_we     = 1'b0;
		left_waddr  = n_q;
		left_wdata  = NULL_LINK;
		right_we    = 1'b0;
		right_waddr = n_q;
		right_wdata = NULL_LINK;
		case (state_q)
			S_INS_W: begin
				left_we  = 1'b1;
				right_we = 1'b1;
			end
			S_INS_L: begin
				left_we     = valid_link(par_q) && !side_q;
				right_we    = valid_link(par_q) && side_q;
				left_waddr  = par_q[IW-1:0];
				right_waddr = par_q[IW-1:0];
				left_wdata  = {1'b0, n_q};
				right_wdata = {1'b0, n_q};
			end
			S_DEL_W1: begin
				left_we     = valid_link(sp_q);
				right_we    = valid_link(sp_q);
				left_waddr  = sp_q[IW-1:0];
				left_wdata  = rs_q;
				right_waddr = s_q;
				right_wdata = rc_q;
			end
			S_DEL_W2: begin
				left_we     = valid_link(par_q) && !side_q;
				right_we    = valid_link(par_q) && side_q;
				left_waddr  = par_q[IW-1:0];
				right_waddr = par_q[IW-1:0];
				left_wdata  = relink_q;
				right_wdata = relink_q;
			end
			S_DEL_W3: begin
				left_we    = 1'b1;
				left_waddr = s_q;
				left_wdata = lc_q;
			end
			default: begin
			end
		endcase
	end

	assign fs_ctrl.push = (state_q == S_DEL_W2 && !two_q) || state_q == S_DEL_W3;
	assign fs_ctrl.pop  = (state_q == S_IDLE && accept && s_tuser == pbst_pkg::OP_INSERT
			&& !valid_link(root_q) && !fs_empty)
		|| (state_q == S_WALK && op_q == pbst_pkg::OP_INSERT && !cmp.eq
			&& !valid_link(next_link) && !fs_empty);

	pbst_ram #(.WIDTH(pbst_pkg::KEY_W), .DEPTH(NODES)) u_key_ram (
		.clk (clk), .we (key_we), .waddr (n_q), .wdata (key_q),
		.re (1'b1), .raddr (raddr), .rdata (key_rd)
	);
	pbst_ram #(.WIDTH(LW), .DEPTH(NODES)) u_left_ram (
		.clk (clk), .we (left_we), .waddr (left_waddr), .wdata (left_wdata),
		.re (1'b1), .raddr (raddr), .rdata (left_rd)
	);
	pbst_ram #(.WIDTH(LW), .DEPTH(NODES)) u_right_ram (
		.clk (clk), .we (right_we), .waddr (right_waddr), .wdata (right_wdata),
		.re (1'b1), .raddr (raddr), .rdata (right_rd)
	);

	pbst_key_cmp u_cmp (
		.node_key  (key_rd),
		.probe_key (key_q),
		.res       (cmp)
	);

	pbst_free_stack #(.NODES(NODES)) u_free (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (fs_ctrl),
		.push_idx (cur_q),
		.pop_idx  (pop_idx),
		.empty    (fs_empty)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			root_q      <= NULL_LINK;
			out_valid_q <= 1'b0;
		end else begin
			// In S_DONE the result register is handled below.
			if (m_tvalid && m_tready && state_q != S_DONE) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						op_q   <= pbst_pkg::op_t'(s_tuser);
						key_q  <= s_tdata;
						cur_q  <= root_q[IW-1:0];
						par_q  <= NULL_LINK;
						side_q <= 1'b0;
						res_idx_q <= '0;
						if (valid_link(root_q)) begin
							state_q <= (s_tuser == pbst_pkg::OP_SMALLEST) ? S_MIN : S_WALK;
						end else if (s_tuser == pbst_pkg::OP_INSERT) begin
							res_status_q <= pbst_pkg::ST_FULL;
							state_q      <= fs_empty ? S_DONE : S_POP;
						end else begin
							res_status_q <= pbst_pkg::ST_NOT_FOUND;
							state_q      <= S_DONE;
						end
					end
				end
				S_WALK: begin
					if (cmp.eq) begin
						res_status_q <= pbst_pkg::ST_OK;
						res_idx_q    <= cur_q;
						lc_q         <= left_rd;
						rc_q         <= right_rd;
						s_q          <= right_rd[IW-1:0];
						sp_q         <= NULL_LINK;
						two_q        <= valid_link(left_rd) && valid_link(right_rd);
						relink_q     <= valid_link(right_rd) ? right_rd : left_rd;
						if (op_q != pbst_pkg::OP_DELETE) begin
							state_q <= S_DONE;
						end else if (valid_link(left_rd) && valid_link(right_rd)) begin
							state_q <= S_SUCC;
						end else begin
							state_q <= S_DEL_W2;
						end
					end else if (valid_link(next_link)) begin
						par_q  <= {1'b0, cur_q};
						side_q <= cmp.node_lt;
						cur_q  <= next_link[IW-1:0];
					end else begin
						// Miss: remember the attach point for an insert.
						par_q  <= {1'b0, cur_q};
						side_q <= cmp.node_lt;
						if (op_q == pbst_pkg::OP_INSERT) begin
							res_status_q <= pbst_pkg::ST_FULL;
							state_q      <= fs_empty ? S_DONE : S_POP;
						end else begin
							res_status_q <= pbst_pkg::ST_NOT_FOUND;
							state_q      <= S_DONE;
						end
					end
				end
				S_MIN: begin
					if (valid_link(left_rd)) begin
						cur_q <= left_rd[IW-1:0];
					end else begin
						res_status_q <= pbst_pkg::ST_OK;
						res_idx_q    <= cur_q;
						state_q      <= S_DONE;
					end
				end
				S_SUCC: begin
					if (valid_link(left_rd)) begin
						sp_q <= {1'b0, s_q};
						s_q  <= left_rd[IW-1:0];
					end else begin
						rs_q     <= right_rd;
						relink_q <= {1'b0, s_q};
						state_q  <= S_DEL_W1;
					end
				end
				S_DEL_W1: state_q <= S_DEL_W2;
				S_DEL_W2: begin
					if (!valid_link(par_q)) begin
						root_q <= relink_q;
					end
					state_q <= two_q ? S_DEL_W3 : S_DONE;
				end
				S_DEL_W3: state_q <= S_DONE;
				S_POP: begin
					n_q     <= pop_idx;
					state_q <= S_INS_W;
				end
				S_INS_W: state_q <= S_INS_L;
				S_INS_L: begin
					if (!valid_link(par_q)) begin
						root_q <= {1'b0, n_q};
					end
					res_status_q <= pbst_pkg::ST_OK;
					res_idx_q    <= n_q;
					state_q      <= S_DONE;
				end
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q  <= 1'b1;
						out_status_q <= res_status_q;
						out_idx_q    <= pbst_pkg::IDX_OUT_W'(res_idx_q);
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {{(pbst_pkg::OUT_DATA_W - pbst_pkg::IDX_OUT_W){1'b0}}, out_idx_q};

	`PBST_ASSERT_NEXT(a_busy_after_request, accept, !s_tready, "request taken while busy")
	`PBST_ASSERT_NEXT(a_push_then_done, fs_ctrl.push, state_q == S_DONE, "free push not final")
	`PBST_ASSERT_NOW(a_root_range, 1'b1, root_q <= NULL_LINK, "root link out of range")
	`PBST_ASSERT_NOW(a_no_pop_and_push, fs_ctrl.pop, !fs_ctrl.push, "pop and push together")
endmodule
`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the pooled binary search tree.
// Depends on pbst_pkg and the pooled_binary_search_tree top level.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
	localparam int NODES      = 1024;
	localparam int LINK_NONE  = NODES;
	localparam int MAX_CYCLES = 4000000;

	typedef struct packed {
		logic signed [63:0] w0;
		logic signed [63:0] w1;
		logic signed [63:0] w2;
		logic signed [63:0] w3;
		logic signed [31:0] tail;
	} tree_key_t;

	typedef struct {
		pbst_pkg::op_t op;
		tree_key_t     key;
		logic          fixed;
		logic [1:0]    st;
		logic [9:0]    idx;
	} req_row_t;

	typedef struct packed {
		logic [1:0] st;
		logic [9:0] idx;
	} reply_t;

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [287:0] s_tdata = '0;
	logic [1:0] s_tuser = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [15:0] m_tdata;
	logic [1:0] m_tuser;

	pooled_binary_search_tree #(.NODES(NODES)) dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	// Shadow copy of the tree.
	int        root;
	int        lft [NODES];
	int        rgt [NODES];
	tree_key_t node_key [NODES];
	int        spare [NODES];
	int        spare_cnt;
	tree_key_t live_keys [$];

	reply_t pending_replies [$];
	int     failures = 0;
	int     cycle_no = 0;
	int     send_idle_pct = 0;
	int     recv_idle_pct = 0;
	bit     recv_hold = 0;

	// Signed lexicographic order: -1 node below probe, 1 above, 0 equal.
	function automatic int key_order(tree_key_t a, tree_key_t b);
		if (a.w0 != b.w0) return a.w0 < b.w0 ? -1 : 1;
		if (a.w1 != b.w1) return a.w1 < b.w1 ? -1 : 1;
		if (a.w2 != b.w2) return a.w2 < b.w2 ? -1 : 1;
		if (a.w3 != b.w3) return a.w3 < b.w3 ? -1 : 1;
		if (a.tail != b.tail) return a.tail < b.tail ? -1 : 1;
		return 0;
	endfunction

	function automatic void tree_clear();
		root = LINK_NONE;
		for (int i = 0; i < NODES; i++) spare[i] = NODES - 1 - i;
		spare_cnt = NODES;
		live_keys.delete();
	endfunction

	function automatic void relink(int parent, int side, int v);
		if (parent == LINK_NONE) root = v;
		else if (side) rgt[parent] = v;
		else lft[parent] = v;
	endfunction

	function automatic void forget_key(tree_key_t k);
		foreach (live_keys[i])
			if (live_keys[i] == k) begin
				live_keys.delete(i);
				return;
			end
	endfunction

	// Applies one request to the shadow tree and returns its reply.
	function automatic reply_t tree_apply(pbst_pkg::op_t op, tree_key_t k);
		reply_t r;
		int cur, parent, side, found, c, nxt;
		r.st = pbst_pkg::ST_NOT_FOUND;
		r.idx = '0;
		cur = root; parent = LINK_NONE; side = 0; found = 0;
		if (op != pbst_pkg::OP_SMALLEST) begin
			while (cur != LINK_NONE) begin
				c = key_order(node_key[cur], k);
				if (c == 0) begin
					found = 1;
					break;
				end
				nxt = c < 0 ? rgt[cur] : lft[cur];
				side = c < 0;
				if (nxt == LINK_NONE) break;
				parent = cur;
				cur = nxt;
			end
		end
		case (op)
			pbst_pkg::OP_SEARCH: if (found) begin
				r.st = pbst_pkg::ST_OK; r.idx = 10'(cur);
			end
			pbst_pkg::OP_INSERT: if (found) begin
				r.st = pbst_pkg::ST_OK; r.idx = 10'(cur);
			end else if (spare_cnt == 0) begin
				r.st = pbst_pkg::ST_FULL;
			end else begin
				int n;
				spare_cnt--;
				n = spare[spare_cnt];
				lft[n] = LINK_NONE; rgt[n] = LINK_NONE; node_key[n] = k;
				// On a miss cur is the attach point (or none for an empty tree).
				relink(cur, side, n);
				live_keys.push_back(k);
				r.st = pbst_pkg::ST_OK; r.idx = 10'(n);
			end
			pbst_pkg::OP_DELETE: if (found) begin
				int lc, rc;
				lc = lft[cur]; rc = rgt[cur];
				if (lc == LINK_NONE) relink(parent, side, rc);
				else if (rc == LINK_NONE) relink(parent, side, lc);
				else begin
					int s, sp;
					s = rc; sp = LINK_NONE;
					while (lft[s] != LINK_NONE) begin
						sp = s; s = lft[s];
					end
					if (sp != LINK_NONE) begin
						lft[sp] = rgt[s];
						rgt[s] = rc;
					end
					relink(parent, side, s);
					lft[s] = lc;
				end
				spare[spare_cnt] = cur;
				spare_cnt++;
				forget_key(k);
				r.st = pbst_pkg::ST_OK; r.idx = 10'(cur);
			end
			default: if (root != LINK_NONE) begin
				cur = root;
				while (lft[cur] != LINK_NONE) cur = lft[cur];
				r.st = pbst_pkg::ST_OK; r.idx = 10'(cur);
			end
		endcase
		return r;
	endfunction

	// Keys drawn mostly from a narrow range so that hits and deep paths occur.
	function automatic tree_key_t pick_key();
		tree_key_t k;
		if (live_keys.size() > 0 && $urandom_range(0, 99) < 45)
			return live_keys[$urandom_range(0, live_keys.size() - 1)];
		if ($urandom_range(0, 9) == 0) begin
			k = {$urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom, $urandom, $urandom};
		end else begin
			k.w0 = $signed(64'($urandom_range(0, 3))) - 2;
			k.w1 = $urandom_range(0, 1) ? -64'sd1 : 64'sd7;
			k.w2 = {$urandom, $urandom};
			k.w3 = $signed(64'($urandom_range(0, 2))) - 1;
			k.tail = $urandom;
		end
		return k;
	endfunction

	// Offers one request and waits until it is taken; the block is busy for the
	// following cycle in any case, so valid is dropped after each request.
	task automatic send_request(pbst_pkg::op_t op, tree_key_t k);
		while (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) @(posedge clk);
		pending_replies.push_back(tree_apply(op, k));
		s_tvalid <= 1;
		s_tdata <= {k.tail, k.w3, k.w2, k.w1, k.w0};
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		s_tvalid <= 0;
		@(posedge clk);
	endtask

	task automatic wait_drained();
		while (pending_replies.size() > 0) @(posedge clk);
	endtask

	always @(posedge clk) begin
		cycle_no <= cycle_no + 1;
		m_tready <= !recv_hold && !(recv_idle_pct > 0 && $urandom_range(0, 99) < recv_idle_pct);
		if (m_tvalid && m_tready) begin
			if (pending_replies.size() == 0) begin
				$display("%0t: unexpected reply status %0d index %0d", $time, m_tuser,
					m_tdata[9:0]);
				failures++;
			end else begin
				reply_t e;
				e = pending_replies.pop_front();
				if (m_tuser !== e.st || m_tdata !== {6'd0, e.idx}) begin
					$display("%0t: mismatch expected status %0d index %0d, got status %0d data %h",
						$time, e.st, e.idx, m_tuser, m_tdata);
					failures++;
				end
			end
		end
		if (cycle_no >= MAX_CYCLES) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic random_phase(int count);
		for (int i = 0; i < count; i++) begin
			int d;
			pbst_pkg::op_t op;
			d = $urandom_range(0, 99);
			op = d < 45 ? pbst_pkg::OP_INSERT : d < 70 ? pbst_pkg::OP_SEARCH :
				d < 92 ? pbst_pkg::OP_DELETE : pbst_pkg::OP_SMALLEST;
			send_request(op, pick_key());
		end
	endtask

	initial begin
		req_row_t rows [$];
		tree_key_t kmax, kmin, kz;
		kmax = {64'sh7fffffffffffffff, 64'sh7fffffffffffffff, 64'sh7fffffffffffffff,
			64'sh7fffffffffffffff, 32'sh7fffffff};
		kmin = {64'sh8000000000000000, 64'sh8000000000000000, 64'sh8000000000000000,
			64'sh8000000000000000, 32'sh80000000};
		kz = '0;
		tree_clear();
		// Empty tree, first allocations in order, duplicates, miss and the child cases.
		rows = '{
			'{pbst_pkg::OP_SMALLEST, kz, 1'b1, pbst_pkg::ST_NOT_FOUND, 10'd0},
			'{pbst_pkg::OP_SEARCH, kz, 1'b1, pbst_pkg::ST_NOT_FOUND, 10'd0},
			'{pbst_pkg::OP_DELETE, kmax, 1'b1, pbst_pkg::ST_NOT_FOUND, 10'd0},
			'{pbst_pkg::OP_INSERT, kz, 1'b1, pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_INSERT, kmax, 1'b1, pbst_pkg::ST_OK, 10'd1},
			'{pbst_pkg::OP_INSERT, kmin, 1'b1, pbst_pkg::ST_OK, 10'd2},
			'{pbst_pkg::OP_INSERT, kz, 1'b1, pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_SMALLEST, kz, 1'b1, pbst_pkg::ST_OK, 10'd2},
			'{pbst_pkg::OP_INSERT, {64'sd0, 64'sd0, 64'sd0, 64'sd0, 32'sd5}, 1'b0,
				pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_INSERT, {64'sd0, 64'sd0, 64'sd0, 64'sd0, -32'sd5}, 1'b0,
				pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_INSERT, {64'sd0, 64'sd0, 64'sd0, 64'sd1, 32'sd0}, 1'b0,
				pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_SEARCH, kmax, 1'b1, pbst_pkg::ST_OK, 10'd1},
			'{pbst_pkg::OP_SEARCH, {64'sd0, 64'sd0, 64'sd0, -64'sd1, 32'sd0}, 1'b1,
				pbst_pkg::ST_NOT_FOUND, 10'd0},
			'{pbst_pkg::OP_DELETE, kz, 1'b0, pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_DELETE, kmin, 1'b0, pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_DELETE, kmax, 1'b0, pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_INSERT, {64'sd3, -64'sd3, 64'sd3, -64'sd3, 32'sd3}, 1'b0,
				pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_SMALLEST, kz, 1'b0, pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_DELETE, {64'sd0, 64'sd0, 64'sd0, 64'sd0, 32'sd5}, 1'b0,
				pbst_pkg::ST_OK, 10'd0},
			'{pbst_pkg::OP_SEARCH, {64'sd0, 64'sd0, 64'sd0, 64'sd1, 32'sd0}, 1'b0,
				pbst_pkg::ST_OK, 10'd0}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		foreach (rows[i]) begin
			if (rows[i].fixed) begin
				reply_t e;
				// Predictor still runs to keep the shadow tree in step.
				e.st = rows[i].st;
				e.idx = rows[i].idx;
				send_request(rows[i].op, rows[i].key);
				if (pending_replies[$] != e) begin
					$display("%0t: predictor disagrees with table row %0d", $time, i);
					failures++;
				end
				pending_replies[$] = e;
			end else begin
				send_request(rows[i].op, rows[i].key);
			end
		end
		wait_drained();

		send_idle_pct = 11; recv_idle_pct = 86;
		random_phase(280);
		send_idle_pct = 86; recv_idle_pct = 11;
		random_phase(140);
		// Long receiver hold-off while requests keep coming.
		send_idle_pct = 0; recv_idle_pct = 0;
		fork
			begin
				recv_hold = 1;
				repeat (400) @(posedge clk);
				recv_hold = 0;
			end
			random_phase(20);
		join
		wait_drained();
		random_phase(60);
		// Exhaust the pool, then try to insert beyond it.
		while (spare_cnt > 0) begin
			tree_key_t k;
			k = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
				$urandom, $urandom};
			send_request(pbst_pkg::OP_INSERT, k);
		end
		send_request(pbst_pkg::OP_INSERT, kz ^ 288'd77);
		send_request(pbst_pkg::OP_INSERT, kmin ^ 288'd3);
		send_request(pbst_pkg::OP_SMALLEST, kz);
		random_phase(80);

		wait_drained();
		repeat (100) @(posedge clk);
		if (failures == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end
endmodule
`default_nettype wire
